// ===== rtl/qrb_pkg.sv =====
// Package for the quadratic RGB blend unit: sizes, payload structs and
// the pipeline control struct. Depends on nothing.
`default_nettype none
package qrb_pkg;

    localparam int CHANNEL_BITS     = 8;
    localparam int WEIGHT_FRAC_BITS = 16;

    localparam int WEIGHT_BITS = WEIGHT_FRAC_BITS + 1;
    localparam int SQ_BITS     = 2 * CHANNEL_BITS;
    localparam int PROD_BITS   = WEIGHT_BITS + SQ_BITS;
    localparam int SUM_BITS    = PROD_BITS + 1;
    localparam int REM_BITS    = SQ_BITS + 2;
    localparam int NUM_LANES   = 4;
    localparam int SQRT_STEPS  = 4;
    localparam int SQRT_STAGES = (CHANNEL_BITS + SQRT_STEPS - 1) / SQRT_STEPS;
    localparam int LANE_STAGES = 3 + SQRT_STAGES;

    localparam logic [WEIGHT_BITS-1:0] W_ONE = WEIGHT_BITS'(1) << WEIGHT_FRAC_BITS;

    typedef enum logic {
        FUNC_ADD = 1'b0,
        FUNC_MIX = 1'b1
    } func_t;

    typedef struct packed {
        func_t                   func;
        logic [CHANNEL_BITS-1:0] first_red;
        logic [CHANNEL_BITS-1:0] first_green;
        logic [CHANNEL_BITS-1:0] first_blue;
        logic [CHANNEL_BITS-1:0] first_alpha;
        logic [CHANNEL_BITS-1:0] second_red;
        logic [CHANNEL_BITS-1:0] second_green;
        logic [CHANNEL_BITS-1:0] second_blue;
        logic [CHANNEL_BITS-1:0] second_alpha;
        logic [WEIGHT_BITS-1:0]  weight_a;
        logic [WEIGHT_BITS-1:0]  weight_b;
        logic                    blend_alpha;
    } in_item_t;

    typedef struct packed {
        logic [CHANNEL_BITS-1:0] out_red;
        logic [CHANNEL_BITS-1:0] out_green;
        logic [CHANNEL_BITS-1:0] out_blue;
        logic [CHANNEL_BITS-1:0] out_alpha;
        logic                    weight_error;
    } out_item_t;

    typedef struct packed {
        logic [LANE_STAGES-1:0] load;
    } lane_ctrl_t;

    typedef struct packed {
        logic                    err;
        logic                    pass_alpha;
        logic [CHANNEL_BITS-1:0] first_alpha;
    } side_t;

    typedef struct packed {
        logic [REM_BITS-1:0]     rem;
        logic [CHANNEL_BITS-1:0] root;
        logic                    sat;
    } sqrt_state_t;

endpackage
`default_nettype wire

// ===== rtl/qrb_lane.sv =====
// One channel lane: squares, weighted products, sum and a pipelined
// digit-by-digit square root with saturation. Depends on qrb_pkg.
`default_nettype none
module qrb_lane
    import qrb_pkg::*;
(
    input  wire logic                    aclk,
    input  wire lane_ctrl_t              ctrl,
    input  wire logic [CHANNEL_BITS-1:0] c1,
    input  wire logic [CHANNEL_BITS-1:0] c2,
    input  wire logic [WEIGHT_BITS-1:0]  wa,
    input  wire logic [WEIGHT_BITS-1:0]  wb,
    output logic      [CHANNEL_BITS-1:0] res
);

    function automatic sqrt_state_t sqrt_step(sqrt_state_t s, int i);
        logic [REM_BITS-1:0] trial;
        sqrt_state_t         r;
        r     = s;
        trial = ({{(REM_BITS - CHANNEL_BITS){1'b0}}, s.root} << (i + 1))
              + (REM_BITS'(1) << (2 * i));
        if (s.rem >= trial) begin
            r.rem  = s.rem - trial;
            r.root = s.root | (CHANNEL_BITS'(1) << i);
        end
        return r;
    endfunction

    logic [SQ_BITS-1:0]     sq1_reg, sq2_reg;
    logic [WEIGHT_BITS-1:0] wa_reg, wb_reg;
    logic [PROD_BITS-1:0]   p1_reg, p2_reg;
    logic [SUM_BITS-1:0]    sum;
    logic [REM_BITS-1:0]    shifted;
    sqrt_state_t            sq_reg [SQRT_STAGES+1];

    always_ff @(posedge aclk) begin
        if (ctrl.load[0]) begin
            sq1_reg <= SQ_BITS'(c1) * SQ_BITS'(c1);
            sq2_reg <= SQ_BITS'(c2) * SQ_BITS'(c2);
            wa_reg  <= wa;
            wb_reg  <= wb;
        end
        if (ctrl.load[1]) begin
            p1_reg <= PROD_BITS'(wa_reg) * PROD_BITS'(sq1_reg);
            p2_reg <= PROD_BITS'(wb_reg) * PROD_BITS'(sq2_reg);
        end
    end

    assign sum     = SUM_BITS'(p1_reg) + SUM_BITS'(p2_reg);
    assign shifted = REM_BITS'(sum >> WEIGHT_FRAC_BITS);

    always_ff @(posedge aclk) begin
        if (ctrl.load[2]) begin
            sq_reg[0].rem  <= {2'b00, shifted[SQ_BITS-1:0]};
            sq_reg[0].root <= '0;
            sq_reg[0].sat  <= |shifted[REM_BITS-1:SQ_BITS];
        end
    end

    for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_sqrt
        sqrt_state_t sq_next;

        always_comb begin
            int bit_idx;
            sq_next = sq_reg[k];
            for (int j = 0; j < SQRT_STEPS; j++) begin
                bit_idx = CHANNEL_BITS - 1 - (k * SQRT_STEPS + j);
                if (bit_idx >= 0) begin
                    sq_next = sqrt_step(sq_next, bit_idx);
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (ctrl.load[3+k]) begin
                sq_reg[k+1] <= sq_next;
            end
        end
    end

    assign res = sq_reg[SQRT_STAGES].sat ? {CHANNEL_BITS{1'b1}} : sq_reg[SQRT_STAGES].root;

endmodule
`default_nettype wire

// ===== rtl/qrb_merge.sv =====
// Merging stage: combines the four lane results with the error flag and
// the alpha pass-through into the registered result. Depends on qrb_pkg.
`default_nettype none
module qrb_merge
    import qrb_pkg::*;
(
    input  wire logic                    aclk,
    input  wire logic                    load,
    input  wire logic [CHANNEL_BITS-1:0] lane_res [NUM_LANES],
    input  wire side_t                   side,
    output out_item_t                    result
);

    out_item_t result_reg, result_next;

    always_comb begin
        result_next.weight_error = side.err;
        if (side.err) begin
            result_next.out_red   = '0;
            result_next.out_green = '0;
            result_next.out_blue  = '0;
            result_next.out_alpha = '0;
        end else begin
            result_next.out_red   = lane_res[0];
            result_next.out_green = lane_res[1];
            result_next.out_blue  = lane_res[2];
            result_next.out_alpha = side.pass_alpha ? side.first_alpha : lane_res[3];
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule
`default_nettype wire

// ===== rtl/quadratic_rgb_blend_unit.sv =====
// Top level of the quadratic RGB blend unit: weight check, four channel
// lanes, sideband pipeline and merge stage. Depends on qrb_pkg, qrb_lane, qrb_merge.
//
//   channel | direction | handshake         | payload
//   s_      | in        | s_valid / s_ready | s_data (in_item_t)
//   m_      | out       | m_valid / m_ready | m_data (out_item_t)
//
// One transaction is accepted per clock while s_ready is high; each result
// passes in turn through the square, multiply, sum and two root stages of
// each lane and then through the output register before it reaches m_data.
// Each stage loads whenever it is empty or the stage after it moves, so
// bubbles close up under a stall. Reset (aresetn low, synchronous) empties
// every stage.
`default_nettype none
module quadratic_rgb_blend_unit
    import qrb_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire in_item_t  s_data,
    output logic           m_valid,
    input  wire logic      m_ready,
    output out_item_t      m_data
);

    localparam int LAST = LANE_STAGES;

    logic [LAST:0] valid_reg, valid_next, load;
    logic [WEIGHT_BITS-1:0] wb_eff;
    logic                   err;
    side_t                  side_in;
    side_t                  side_reg [LANE_STAGES];
    lane_ctrl_t             lane_ctrl;
    logic [CHANNEL_BITS-1:0] c1 [NUM_LANES];
    logic [CHANNEL_BITS-1:0] c2 [NUM_LANES];
    logic [CHANNEL_BITS-1:0] lane_res [NUM_LANES];

    always_comb begin
        load[LAST] = !valid_reg[LAST] || m_ready;
        for (int i = LAST - 1; i >= 0; i--) begin
            load[i] = !valid_reg[i] || load[i+1];
        end
        valid_next = valid_reg;
        if (load[0]) begin
            valid_next[0] = s_valid;
        end
        for (int i = 1; i <= LAST; i++) begin
            if (load[i]) begin
                valid_next[i] = valid_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign s_ready = load[0];
    assign m_valid = valid_reg[LAST];

    always_comb begin
        unique case (s_data.func)
            FUNC_MIX: begin
                err    = s_data.weight_a > W_ONE;
                wb_eff = W_ONE - s_data.weight_a;
            end
            FUNC_ADD: begin
                err    = (s_data.weight_a > W_ONE) || (s_data.weight_b > W_ONE);
                wb_eff = s_data.weight_b;
            end
            default: begin
                err    = 1'b1;
                wb_eff = s_data.weight_b;
            end
        endcase
    end

    assign side_in.err         = err;
    assign side_in.pass_alpha  = !s_data.blend_alpha;
    assign side_in.first_alpha = s_data.first_alpha;

    always_ff @(posedge aclk) begin
        if (load[0]) begin
            side_reg[0] <= side_in;
        end
        for (int i = 1; i < LANE_STAGES; i++) begin
            if (load[i]) begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    assign lane_ctrl.load = load[LANE_STAGES-1:0];

    assign c1[0] = s_data.first_red;
    assign c1[1] = s_data.first_green;
    assign c1[2] = s_data.first_blue;
    assign c1[3] = s_data.first_alpha;
    assign c2[0] = s_data.second_red;
    assign c2[1] = s_data.second_green;
    assign c2[2] = s_data.second_blue;
    assign c2[3] = s_data.second_alpha;

    for (genvar n = 0; n < NUM_LANES; n++) begin : g_lane
        qrb_lane u_lane (
            .aclk (aclk),
            .ctrl (lane_ctrl),
            .c1   (c1[n]),
            .c2   (c2[n]),
            .wa   (s_data.weight_a),
            .wb   (wb_eff),
            .res  (lane_res[n])
        );
    end

    qrb_merge u_merge (
        .aclk     (aclk),
        .load     (load[LAST]),
        .lane_res (lane_res),
        .side     (side_reg[LANE_STAGES-1]),
        .result   (m_data)
    );

    a_error_zeroes: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.weight_error |->
            m_data.out_red == '0 && m_data.out_green == '0 &&
            m_data.out_blue == '0 && m_data.out_alpha == '0)
        else $error("weight error result carries nonzero channels");

    a_empty_output_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !valid_reg[LAST] |-> s_ready)
        else $error("input stalled while the output stage is empty");

    a_first_stage_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg[0] && !load[1] |=> valid_reg[0] && $stable(side_reg[0]))
        else $error("first stage lost or changed a stalled transaction");

    a_mix_no_error: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_data.func == FUNC_MIX && s_data.weight_a <= W_ONE
            |=> !side_reg[0].err)
        else $error("mix mode flagged an error for a valid weight");

endmodule
`default_nettype wire

// ===== tb/sv/quadratic_rgb_blend_unit_test.sv =====
// Self-checking testbench for quadratic_rgb_blend_unit: directed, random, back-pressure
// and full-rate tests against a predictor of the root-mean-square RGBA blend.
// Depends on qrb_pkg and the quadratic_rgb_blend_unit RTL.
module quadratic_rgb_blend_unit_test;
    timeunit 1ns;
    timeprecision 1ps;
    import qrb_pkg::*;

    localparam int HOLD_OFF_CYCLES = 250;
    localparam int DRAIN_LIMIT     = 5000;
    localparam int SETTLE_CYCLES   = 16;
    localparam int RANDOM_ITEMS    = 1300;
    localparam logic [CHANNEL_BITS-1:0] CHAN_MAX = '1;
    localparam logic [WEIGHT_BITS-1:0]  W_MAX    = '1;

    typedef enum logic [1:0] {
        READY_ALWAYS,
        READY_RANDOM,
        READY_PATTERN
    } ready_mode_t;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;

    out_item_t   predicted_blends[$];
    int          mismatch_count = 0;
    ready_mode_t ready_mode     = READY_ALWAYS;
    int unsigned hold_requests  = 0;
    int unsigned hold_served    = 0;
    int unsigned hold_left      = 0;
    logic [15:0] stall_pattern  = 16'hffff;
    logic [3:0]  pattern_phase  = 4'h0;
    bit          sender_idles   = 1'b0;
    int          burst_left     = 0;

    quadratic_rgb_blend_unit uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic logic [CHANNEL_BITS-1:0] rms_channel(
        logic [CHANNEL_BITS-1:0] c1, logic [CHANNEL_BITS-1:0] c2,
        logic [WEIGHT_BITS-1:0] wa, logic [WEIGHT_BITS-1:0] wb);
        logic [63:0] acc;
        logic [63:0] root;
        logic [63:0] cand;
        acc = 64'(wa) * 64'(c1) * 64'(c1) + 64'(wb) * 64'(c2) * 64'(c2);
        acc = acc >> WEIGHT_FRAC_BITS;
        root = '0;
        for (int b = 31; b >= 0; b--) begin
            cand = root | (64'd1 << b);
            if (cand * cand <= acc) root = cand;
        end
        return (root > 64'(CHAN_MAX)) ? CHAN_MAX : root[CHANNEL_BITS-1:0];
    endfunction

    function automatic out_item_t predict_blend(in_item_t px);
        out_item_t r;
        logic [WEIGHT_BITS-1:0] wa;
        logic [WEIGHT_BITS-1:0] wb;
        logic over;
        wa = px.weight_a;
        wb = px.weight_b;
        if (px.func == FUNC_MIX) begin
            over = wa > W_ONE;
            wb = W_ONE - wa;
        end else begin
            over = (wa > W_ONE) || (wb > W_ONE);
        end
        r = '0;
        if (over) begin
            r.weight_error = 1'b1;
        end else begin
            r.out_red   = rms_channel(px.first_red, px.second_red, wa, wb);
            r.out_green = rms_channel(px.first_green, px.second_green, wa, wb);
            r.out_blue  = rms_channel(px.first_blue, px.second_blue, wa, wb);
            r.out_alpha = px.blend_alpha ? rms_channel(px.first_alpha, px.second_alpha, wa, wb)
                                         : px.first_alpha;
        end
        return r;
    endfunction

    function automatic in_item_t pixel_pair(func_t f, logic [31:0] first, logic [31:0] second,
                                            logic [WEIGHT_BITS-1:0] wa,
                                            logic [WEIGHT_BITS-1:0] wb, logic ba);
        in_item_t px;
        px.func = f;
        {px.first_red, px.first_green, px.first_blue, px.first_alpha} = first;
        {px.second_red, px.second_green, px.second_blue, px.second_alpha} = second;
        px.weight_a = wa;
        px.weight_b = wb;
        px.blend_alpha = ba;
        return px;
    endfunction

    function automatic logic [CHANNEL_BITS-1:0] random_channel();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return CHAN_MAX;
            default: return CHANNEL_BITS'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [WEIGHT_BITS-1:0] random_weight();
        case ($urandom_range(0, 11))
            0: return '0;
            1: return W_ONE;
            2: return WEIGHT_BITS'($urandom_range(int'(W_ONE) + 1, int'(W_MAX)));
            3: return WEIGHT_BITS'($urandom_range(0, int'(W_MAX)));
            default: return WEIGHT_BITS'($urandom_range(0, int'(W_ONE)));
        endcase
    endfunction

    function automatic in_item_t random_item();
        in_item_t px;
        px.func         = func_t'($urandom_range(0, 1));
        px.first_red    = random_channel();
        px.first_green  = random_channel();
        px.first_blue   = random_channel();
        px.first_alpha  = random_channel();
        px.second_red   = random_channel();
        px.second_green = random_channel();
        px.second_blue  = random_channel();
        px.second_alpha = random_channel();
        px.weight_a     = random_weight();
        px.weight_b     = random_weight();
        px.blend_alpha  = 1'($urandom_range(0, 1));
        return px;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t ns: %s", $realtime, msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want)
            report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    task automatic send_pixel_pair(input in_item_t px);
        int gap;
        bit taken;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = sender_idles ? $urandom_range(0, 6) : 0;
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        s_valid <= 1'b1;
        s_data  <= px;
        do begin
            @(negedge aclk);
            taken = s_ready;
            if (taken) predicted_blends.push_back(predict_blend(px));
            @(posedge aclk);
        end while (!taken);
        burst_left--;
    endtask

    always @(posedge aclk) begin
        if (hold_requests != hold_served) begin
            hold_served <= hold_requests;
            hold_left   <= HOLD_OFF_CYCLES;
            m_ready     <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            case (ready_mode)
                READY_ALWAYS: m_ready <= 1'b1;
                READY_RANDOM: m_ready <= ($urandom_range(0, 99) < 65);
                default:      m_ready <= stall_pattern[0] | stall_pattern[7];
            endcase
        end
        pattern_phase <= pattern_phase + 4'h1;
        stall_pattern <= (pattern_phase == 4'hf) ? 16'($urandom)
                                                 : {stall_pattern[0], stall_pattern[15:1]};
    end

    always @(negedge aclk) begin : check_results
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (predicted_blends.size() == 0) begin
                report_mismatch("result transaction with no pending prediction");
            end else begin
                want = predicted_blends.pop_front();
                check_field("out_red", int'(m_data.out_red), int'(want.out_red));
                check_field("out_green", int'(m_data.out_green), int'(want.out_green));
                check_field("out_blue", int'(m_data.out_blue), int'(want.out_blue));
                check_field("out_alpha", int'(m_data.out_alpha), int'(want.out_alpha));
                check_field("weight_error", int'(m_data.weight_error),
                            int'(want.weight_error));
            end
        end
    end

    task automatic test_directed_cases();
        sender_idles = 1'b1;
        ready_mode <= READY_RANDOM;
        send_pixel_pair(pixel_pair(FUNC_ADD, 32'h00000000, 32'h00000000, '0, '0, 1'b0));
        send_pixel_pair(pixel_pair(FUNC_ADD, 32'hffffffff, 32'hffffffff, W_ONE, W_ONE, 1'b1));
        send_pixel_pair(pixel_pair(FUNC_ADD, 32'h12345678, 32'h9abcdef0, W_ONE, '0, 1'b1));
        send_pixel_pair(pixel_pair(FUNC_MIX, 32'h11223344, 32'h8899aabb, '0, W_MAX, 1'b1));
        send_pixel_pair(pixel_pair(FUNC_MIX, 32'hff00ff00, 32'h00ff00ff, W_ONE, '0, 1'b0));
        send_pixel_pair(pixel_pair(FUNC_MIX, 32'hff804020, 32'h204080ff, 17'd32768, '0, 1'b1));
        send_pixel_pair(pixel_pair(FUNC_MIX, 32'hffffffff, 32'hffffffff, W_ONE + 1'b1, '0, 1'b1));
        send_pixel_pair(pixel_pair(FUNC_ADD, 32'hffffffff, 32'hffffffff, '0, W_ONE + 1'b1, 1'b0));
        send_pixel_pair(pixel_pair(FUNC_ADD, 32'hffffffff, 32'hffffffff, W_MAX, W_MAX, 1'b1));
        send_pixel_pair(pixel_pair(FUNC_ADD, 32'h80808080, 32'h40404040, W_MAX, '0, 1'b0));
        send_pixel_pair(pixel_pair(FUNC_MIX, 32'h102030a5, 32'hf0e0d05a, 17'd40000, '0, 1'b0));
        send_pixel_pair(pixel_pair(FUNC_ADD, 32'hc0c0c0c0, 32'hc0c0c0c0, 17'd60000, 17'd60000,
                                   1'b1));
        send_pixel_pair(pixel_pair(FUNC_ADD, 32'hffffffff, 32'hffffffff, 17'd1, 17'd1, 1'b1));
        send_pixel_pair(pixel_pair(FUNC_MIX, 32'hffffffff, 32'h00000000, 17'd1, W_MAX, 1'b1));
        send_pixel_pair(pixel_pair(FUNC_ADD, 32'h00000000, 32'hffffffff, W_ONE, W_ONE, 1'b0));
        send_pixel_pair(pixel_pair(FUNC_ADD, 32'hffffffff, 32'h00000000, W_ONE, W_ONE, 1'b1));
        send_pixel_pair(pixel_pair(FUNC_MIX, 32'h0000ff01, 32'hff00017f, W_ONE - 1'b1, W_ONE,
                                   1'b1));
    endtask

    task automatic test_random_blends(input int count);
        for (int i = 0; i < count; i++) begin
            if (i % 100 == 0) begin
                ready_mode <= ready_mode_t'($urandom_range(0, 2));
                sender_idles = ($urandom_range(0, 3) != 0);
            end
            send_pixel_pair(random_item());
        end
    endtask

    task automatic test_backpressure_fill();
        sender_idles = 1'b0;
        ready_mode <= READY_ALWAYS;
        hold_requests <= hold_requests + 1;
        repeat (48) send_pixel_pair(random_item());
    endtask

    task automatic test_full_rate_stream();
        sender_idles = 1'b0;
        ready_mode <= READY_ALWAYS;
        repeat (64) send_pixel_pair(random_item());
    endtask

    initial begin : run_tests
        int waited;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);
        test_directed_cases();
        test_random_blends(RANDOM_ITEMS);
        test_backpressure_fill();
        test_full_rate_stream();
        s_valid <= 1'b0;
        ready_mode <= READY_ALWAYS;
        waited = 0;
        while (predicted_blends.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (predicted_blends.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", predicted_blends.size()));
        if (mismatch_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin : run_limit
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
